/* design/fwrp_pkg.sv */
`default_nettype none
package fwrp_pkg;

   localparam int NUM_ENTRIES_DEFAULT = 16;
   localparam int WEIGHT_W = 16;
   localparam int FRAC_W = 24;
   localparam int TOTAL_W = 20;
   localparam logic [TOTAL_W-1:0] TOTAL_MAX = 20'hFFFFF;

   localparam logic ACTION_WRITE = 1'b0;
   localparam logic ACTION_PICK = 1'b1;

   typedef struct packed {
      logic        action;
      logic [3:0]  slot;
      logic [15:0] weight;
      logic        has_members;
      logic [15:0] military;
      logic [15:0] population;
      logic [15:0] wealth;
      logic [7:0]  category_mask;
      logic [2:0]  category;
      logic [31:0] seed;
   } req_type;

   typedef struct packed {
      logic        found;
      logic [3:0]  chosen_slot;
      logic [19:0] total_weight;
   } rsp_type;

   typedef struct packed {
      logic [15:0] weight;
      logic [15:0] min_wealth;
      logic [15:0] min_population;
      logic [15:0] min_military;
      logic [7:0]  cat_mask;
      logic        has_members;
   } entry_type;

   // datapath operations of one microcode step
   typedef struct packed {
      logic load;
      logic clear;
      logic rd;
      logic sum;
      logic mul;
      logic clear_scan;
      logic run;
      logic wr;
      logic respond;
   } ctrl_type;

   typedef struct packed {
      logic is_write;
      logic more;
      logic total_zero;
   } stat_type;

   typedef enum logic [2:0] {
      JC_NONE,
      JC_ALWAYS,
      JC_NO_START,
      JC_IF_WRITE,
      JC_IF_MORE,
      JC_IF_ZERO
   } jc_type;

   localparam int STEP_W = 4;
   typedef logic [STEP_W-1:0] step_type;

   localparam step_type STEP_IDLE     = 4'd0;
   localparam step_type STEP_SETUP    = 4'd1;
   localparam step_type STEP_SUM      = 4'd2;
   localparam step_type STEP_SUM_END  = 4'd3;
   localparam step_type STEP_ROLL     = 4'd4;
   localparam step_type STEP_SCAN     = 4'd5;
   localparam step_type STEP_SCAN_END = 4'd6;
   localparam step_type STEP_RESP     = 4'd7;
   localparam step_type STEP_WRITE    = 4'd8;

   typedef struct packed {
      ctrl_type ops;
      jc_type   jc;
      step_type target;
   } ucode_type;

   function automatic ucode_type ucode_rom(step_type pc);
      ucode_type w;
      w = '0;
      w.jc = JC_NONE;
      unique case (pc)
         STEP_IDLE: begin
            w.ops.load = 1'b1;
            w.jc = JC_NO_START;
            w.target = STEP_IDLE;
         end
         STEP_SETUP: begin
            w.ops.clear = 1'b1;
            w.jc = JC_IF_WRITE;
            w.target = STEP_WRITE;
         end
         STEP_SUM: begin
            w.ops.rd = 1'b1;
            w.ops.sum = 1'b1;
            w.jc = JC_IF_MORE;
            w.target = STEP_SUM;
         end
         STEP_SUM_END: begin
            w.ops.sum = 1'b1;
         end
         STEP_ROLL: begin
            w.ops.mul = 1'b1;
            w.ops.clear_scan = 1'b1;
            w.jc = JC_IF_ZERO;
            w.target = STEP_RESP;
         end
         STEP_SCAN: begin
            w.ops.rd = 1'b1;
            w.ops.run = 1'b1;
            w.jc = JC_IF_MORE;
            w.target = STEP_SCAN;
         end
         STEP_SCAN_END: begin
            w.ops.run = 1'b1;
         end
         STEP_RESP: begin
            w.ops.respond = 1'b1;
            w.jc = JC_ALWAYS;
            w.target = STEP_IDLE;
         end
         STEP_WRITE: begin
            w.ops.wr = 1'b1;
            w.jc = JC_ALWAYS;
            w.target = STEP_RESP;
         end
         default: begin
            w.jc = JC_ALWAYS;
            w.target = STEP_IDLE;
         end
      endcase
      return w;
   endfunction

endpackage
`default_nettype wire

/* design/fwrp_ram.sv */
`default_nettype none
module fwrp_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  wire logic                                clock,
   input  wire logic                                wr_en,
   input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]                    wr_data,
   input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic      [WIDTH-1:0]                    rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data <= mem_ff[rd_addr];
   end

endmodule
`default_nettype wire

/* design/fwrp_seq.sv */
`default_nettype none
module fwrp_seq (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                start,
   input  wire fwrp_pkg::stat_type  stat,
   output fwrp_pkg::ctrl_type       ctrl,
   output logic                     busy
);

   fwrp_pkg::step_type  pc_ff;
   fwrp_pkg::step_type  pc_in;
   fwrp_pkg::ucode_type word;
   logic                take;

   assign word = fwrp_pkg::ucode_rom(pc_ff);
   assign busy = (pc_ff != fwrp_pkg::STEP_IDLE);

   always_comb begin
      ctrl = word.ops;
      ctrl.load = word.ops.load & start & ~busy;
      unique case (word.jc)
         fwrp_pkg::JC_NONE:     take = 1'b0;
         fwrp_pkg::JC_ALWAYS:   take = 1'b1;
         fwrp_pkg::JC_NO_START: take = ~start;
         fwrp_pkg::JC_IF_WRITE: take = stat.is_write;
         fwrp_pkg::JC_IF_MORE:  take = stat.more;
         fwrp_pkg::JC_IF_ZERO:  take = stat.total_zero;
         default:               take = 1'b1;
      endcase
      pc_in = take ? word.target : pc_ff + 4'd1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pc_ff <= fwrp_pkg::STEP_IDLE;
      end else begin
         pc_ff <= pc_in;
      end
   end

endmodule
`default_nettype wire

/* design/fwrp_datapath.sv */
`default_nettype none
module fwrp_datapath #(
   parameter int NUM_ENTRIES = fwrp_pkg::NUM_ENTRIES_DEFAULT
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire fwrp_pkg::req_type  req_data,
   input  wire fwrp_pkg::ctrl_type ctrl,
   output fwrp_pkg::stat_type      stat,
   output fwrp_pkg::rsp_type       rsp_data
);

   localparam int AW = (NUM_ENTRIES > 1) ? $clog2(NUM_ENTRIES) : 1;
   localparam int SUM_W = fwrp_pkg::WEIGHT_W + $clog2(NUM_ENTRIES);
   localparam int SAT_W = (SUM_W > fwrp_pkg::TOTAL_W) ? SUM_W : fwrp_pkg::TOTAL_W;
   localparam int PROD_W = fwrp_pkg::FRAC_W + SUM_W;

   fwrp_pkg::req_type   req_ff;
   fwrp_pkg::entry_type wr_entry;
   fwrp_pkg::entry_type rd_entry;

   logic [AW-1:0]          idx_ff, idx_in;
   logic [AW-1:0]          rd_idx_ff;
   logic                   rd_pend_ff;
   logic                   rd_valid_ff;
   logic [NUM_ENTRIES-1:0] valid_ff;
   logic [SUM_W-1:0]       total_ff, total_in;
   logic [SUM_W-1:0]       run_ff, run_in;
   logic [SUM_W-1:0]       roll_ff, roll_in;
   logic [AW-1:0]          pick_ff, pick_in;
   logic                   any_ff, any_in;
   logic                   hit_ff, hit_in;

   logic [AW+3:0]          slot_ext;
   logic [AW+3:0]          pick_ext;
   logic [AW-1:0]          wr_addr;
   logic                   wr_en;
   logic                   eligible;
   logic [SUM_W-1:0]       weight_ext;
   logic [SUM_W-1:0]       run_next;
   logic [PROD_W-1:0]      product;
   logic [SAT_W-1:0]       total_wide;

   assign slot_ext = {{AW{1'b0}}, req_ff.slot};
   assign wr_addr  = slot_ext[AW-1:0];
   assign wr_en    = ctrl.wr && (slot_ext < (AW+4)'(NUM_ENTRIES));

   assign wr_entry.weight         = req_ff.weight;
   assign wr_entry.min_wealth     = req_ff.wealth;
   assign wr_entry.min_population = req_ff.population;
   assign wr_entry.min_military   = req_ff.military;
   assign wr_entry.cat_mask       = req_ff.category_mask;
   assign wr_entry.has_members    = req_ff.has_members;

   fwrp_ram #(
      .WIDTH($bits(fwrp_pkg::entry_type)),
      .DEPTH(NUM_ENTRIES)
   ) u_table (
      .clock  (clock),
      .wr_en  (wr_en),
      .wr_addr(wr_addr),
      .wr_data(wr_entry),
      .rd_addr(idx_ff),
      .rd_data(rd_entry)
   );

   // an entry never written has its valid bit clear, so it is ineligible
   assign eligible = rd_pend_ff && rd_valid_ff
      && (rd_entry.weight != '0) && rd_entry.has_members
      && (req_ff.military >= rd_entry.min_military)
      && (req_ff.population >= rd_entry.min_population)
      && (req_ff.wealth >= rd_entry.min_wealth)
      && ((rd_entry.cat_mask == '0) || rd_entry.cat_mask[req_ff.category]);

   assign weight_ext = SUM_W'(rd_entry.weight);
   assign run_next   = run_ff + weight_ext;
   assign product    = PROD_W'(req_ff.seed[fwrp_pkg::FRAC_W-1:0]) * PROD_W'(total_ff);

   always_comb begin
      idx_in   = idx_ff;
      total_in = total_ff;
      run_in   = run_ff;
      roll_in  = roll_ff;
      pick_in  = pick_ff;
      any_in   = any_ff;
      hit_in   = hit_ff;
      if (ctrl.clear) begin
         idx_in   = '0;
         total_in = '0;
         pick_in  = '0;
         any_in   = 1'b0;
      end
      if (ctrl.clear_scan) begin
         idx_in = '0;
         run_in = '0;
         hit_in = 1'b0;
      end
      if (ctrl.rd) begin
         idx_in = idx_ff + AW'(1);
      end
      if (ctrl.sum && eligible) begin
         total_in = total_ff + weight_ext;
      end
      if (ctrl.mul) begin
         roll_in = product[PROD_W-1:fwrp_pkg::FRAC_W];
      end
      // freeze the pick once the running sum has passed the roll
      if (ctrl.run && eligible && !hit_ff) begin
         run_in  = run_next;
         pick_in = rd_idx_ff;
         any_in  = 1'b1;
         if (roll_ff < run_next) begin
            hit_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.load) begin
         req_ff <= req_data;
      end
      if (ctrl.rd) begin
         rd_idx_ff   <= idx_ff;
         rd_valid_ff <= valid_ff[idx_ff];
      end
      idx_ff   <= idx_in;
      total_ff <= total_in;
      run_ff   <= run_in;
      roll_ff  <= roll_in;
      pick_ff  <= pick_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_pend_ff <= 1'b0;
         valid_ff   <= '0;
         any_ff     <= 1'b0;
         hit_ff     <= 1'b0;
      end else begin
         rd_pend_ff <= ctrl.rd;
         any_ff     <= any_in;
         hit_ff     <= hit_in;
         if (wr_en) begin
            valid_ff[wr_addr] <= 1'b1;
         end
      end
   end

   assign stat.is_write   = (req_ff.action == fwrp_pkg::ACTION_WRITE);
   assign stat.more       = (idx_ff != AW'(NUM_ENTRIES - 1));
   assign stat.total_zero = (total_ff == '0);

   assign total_wide = SAT_W'(total_ff);
   assign pick_ext   = {4'b0000, pick_ff};

   assign rsp_data.found        = any_ff;
   assign rsp_data.chosen_slot  = any_ff ? pick_ext[3:0] : 4'b0000;
   assign rsp_data.total_weight = (total_wide > SAT_W'(fwrp_pkg::TOTAL_MAX))
      ? fwrp_pkg::TOTAL_MAX : total_wide[fwrp_pkg::TOTAL_W-1:0];

endmodule
`default_nettype wire

/* design/filtered_weighted_random_pick.sv */
// Weighted random pick over a table of NUM_ENTRIES entries. A transaction is taken when start
// is high and busy is low; action 0 loads one table entry, action 1 draws an entry whose
// thresholds and category mask the requester meets, with probability proportional to its
// weight. Every transaction gives exactly one result, shown for a single cycle with rsp_valid;
// the receiver cannot stall, so it must take rsp_data in that cycle. A pick makes two
// sequential passes over the table's single read port, one to total the eligible weights and
// one to walk the running sum against the roll; a pick with zero eligible weight ends after
// the first pass, and a write makes no pass. After reset no table entry is eligible until it
// is written.
`default_nettype none
module filtered_weighted_random_pick #(
   parameter int NUM_ENTRIES = fwrp_pkg::NUM_ENTRIES_DEFAULT
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              start,
   output logic                   busy,
   input  wire fwrp_pkg::req_type req_data,
   output logic                   rsp_valid,
   output fwrp_pkg::rsp_type      rsp_data
);

   fwrp_pkg::ctrl_type ctrl;
   fwrp_pkg::stat_type stat;

   fwrp_seq u_seq (
      .clock(clock),
      .reset(reset),
      .start(start),
      .stat (stat),
      .ctrl (ctrl),
      .busy (busy)
   );

   fwrp_datapath #(
      .NUM_ENTRIES(NUM_ENTRIES)
   ) u_datapath (
      .clock   (clock),
      .reset   (reset),
      .req_data(req_data),
      .ctrl    (ctrl),
      .stat    (stat),
      .rsp_data(rsp_data)
   );

   assign rsp_valid = ctrl.respond;

   a_rsp_in_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> busy)
      else $error("result strobe outside a transaction");

   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("accepted transaction did not raise busy");

   a_rsp_ends: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !busy && !rsp_valid)
      else $error("sequencer did not return to idle after result");

   a_found_total: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.found) |-> (rsp_data.total_weight != '0))
      else $error("pick found with zero total weight");

   a_no_pick_slot: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_data.found) |-> (rsp_data.chosen_slot == 4'b0000))
      else $error("slot reported without a pick");

endmodule
`default_nettype wire
